### design/pfpi_pkg.sv
// Shared constants and types for the parabolic peak finder.
`default_nettype none

package pfpi_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS    = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int INDEX_BITS     = 12;
    localparam int POSITION_BITS  = 28;

    // Widest peak index that a job carries (array length up to 65536)
    localparam int JOB_INDEX_BITS = 16;

    // Defaults for top-level parameters
    localparam int MAX_LENGTH_DEFAULT  = 4096;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // One finished array, handed from the front to the back
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] peak;
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [JOB_INDEX_BITS-1:0]     index;
        logic                          interior;
    } job_t;

endpackage

`default_nettype wire

### design/pfpi_front.sv
// Front part: running argmax with neighbor capture, emits one job per array.
`default_nettype none

module pfpi_front
    import pfpi_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last,
    input  wire logic                          q_full,
    output logic                               q_push,
    output job_t                               q_job
);

    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int PW = $clog2(MAX_LENGTH);

    logic signed [SAMPLE_BITS-1:0] best_value_reg, best_value_next;
    logic [PW-1:0]                 best_pos_reg, best_pos_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, left_next;
    logic signed [SAMPLE_BITS-1:0] right_reg, right_next;
    logic                          pending_reg, pending_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic                          accept;

    // Stall only a marked sample that finds the queue full
    assign sample_ready = !(last && q_full);
    assign accept       = sample_valid && sample_ready;
    assign q_push       = accept && last;

    // Update the running peak and its neighbors
    always_comb
    begin
        best_value_next = best_value_reg;
        best_pos_next   = best_pos_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        pending_next    = pending_reg;
        prev_next       = prev_reg;
        count_next      = count_reg;
        if (count_reg < CW'(MAX_LENGTH))
        begin
            if (count_reg == '0 || sample > best_value_reg)
            begin
                best_value_next = sample;
                best_pos_next   = count_reg[PW-1:0];
                left_next       = prev_reg;
                pending_next    = 1'b1;
            end
            else if (pending_reg)
            begin
                right_next   = sample;
                pending_next = 1'b0;
            end
            prev_next  = sample;
            count_next = count_reg + CW'(1);
        end
    end

    // Build the job from the state as it stands after this sample
    always_comb
    begin
        q_job.peak     = best_value_next;
        q_job.left     = left_next;
        q_job.right    = right_next;
        q_job.index    = JOB_INDEX_BITS'(best_pos_next);
        q_job.interior = (best_pos_next != '0) && !pending_next;
    end

    // Advance on each transfer, clear after the marked sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_value_reg <= '0;
            best_pos_reg   <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            pending_reg    <= 1'b0;
            prev_reg       <= '0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                best_value_reg <= '0;
                best_pos_reg   <= '0;
                left_reg       <= '0;
                right_reg      <= '0;
                pending_reg    <= 1'b0;
                prev_reg       <= '0;
                count_reg      <= '0;
            end
            else
            begin
                best_value_reg <= best_value_next;
                best_pos_reg   <= best_pos_next;
                left_reg       <= left_next;
                right_reg      <= right_next;
                pending_reg    <= pending_next;
                prev_reg       <= prev_next;
                count_reg      <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

### design/pfpi_queue.sv
// Small job queue between the front and the back parts.
`default_nettype none

module pfpi_queue
    import pfpi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      pop_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [NW-1:0] fill_reg;

    assign full      = (fill_reg == NW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("job queue popped while empty");

endmodule

`default_nettype wire

### design/pfpi_back.sv
// Back part: parabolic offset by restoring division, and the result register.
`default_nettype none

module pfpi_back
    import pfpi_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_not_empty,
    input  wire job_t                      q_job,
    output logic                           q_pop,
    output logic                           result_valid,
    input  wire logic                      result_ready,
    output logic [POSITION_BITS-1:0]       peak_position,
    output logic [INDEX_BITS-1:0]          peak_index,
    output logic                           interpolated
);

    localparam int SB = SAMPLE_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int DW = SB + 2;
    localparam int KW = (F > 1) ? $clog2(F) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [SB-1:0]             p_reg, p_next;
    logic [SB-1:0]             q_reg, q_next;
    logic [JOB_INDEX_BITS-1:0] pos_reg, pos_next;
    logic [DW-1:0]             den_reg, den_next;
    logic [DW-1:0]             rem_reg, rem_next;
    logic                      neg_reg, neg_next;
    logic [F-1:0]              quot_reg, quot_next;
    logic [KW-1:0]             step_reg, step_next;
    logic [POSITION_BITS-1:0]  res_pos_reg, res_pos_next;
    logic                      res_interp_reg, res_interp_next;
    logic                      out_valid_reg;
    logic [POSITION_BITS-1:0]  out_pos_reg;
    logic [INDEX_BITS-1:0]     out_idx_reg;
    logic                      out_interp_reg;
    logic                      out_load;

    logic [SB:0]               diff_p;
    logic [SB:0]               diff_q;
    logic [SB:0]               sum_pq;
    logic [DW:0]               rem_shift;
    logic [F:0]                offset;
    logic [POSITION_BITS-1:0]  base_pos;

    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result_ready);

    // Distances from the peak down to its neighbors, both nonnegative
    assign diff_p = {q_job.peak[SB-1], q_job.peak} - {q_job.left[SB-1], q_job.left};
    assign diff_q = {q_job.peak[SB-1], q_job.peak} - {q_job.right[SB-1], q_job.right};
    assign sum_pq = {1'b0, p_reg} + {1'b0, q_reg};

    assign rem_shift = {rem_reg, 1'b0};
    assign base_pos  = POSITION_BITS'(pos_reg) << F;

    // Floor of the signed quotient: -x-1 is ~x, -x is ~x+1
    assign offset = neg_reg ? (~{1'b0, quot_reg} + (F+1)'(rem_reg == '0))
                            : {1'b0, quot_reg};

    // Sequence one job through setup, division and result; an edge peak or a zero denominator skips the division
    always_comb
    begin
        state_next      = state_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        pos_next        = pos_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        neg_next        = neg_reg;
        quot_next       = quot_reg;
        step_next       = step_reg;
        res_pos_next    = res_pos_reg;
        res_interp_next = res_interp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    p_next   = diff_p[SB-1:0];
                    q_next   = diff_q[SB-1:0];
                    pos_next = q_job.index;
                    if (q_job.interior)
                    begin
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        res_pos_next    = POSITION_BITS'(q_job.index) << F;
                        res_interp_next = 1'b0;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_PREP:
            begin
                den_next  = {sum_pq, 1'b0};
                neg_next  = q_reg > p_reg;
                rem_next  = (q_reg > p_reg) ? DW'(q_reg - p_reg) : DW'(p_reg - q_reg);
                quot_next = '0;
                step_next = '0;
                if (sum_pq == '0)
                begin
                    res_pos_next    = base_pos;
                    res_interp_next = 1'b0;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_next  = DW'(rem_shift - {1'b0, den_reg});
                    quot_next = {quot_reg[F-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[DW-1:0];
                    quot_next = {quot_reg[F-2:0], 1'b0};
                end
                step_next = step_reg + KW'(1);
                if (step_reg == KW'(F - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                res_pos_next    = base_pos
                                  + {{(POSITION_BITS - F - 1){offset[F]}}, offset};
                res_interp_next = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the working registers
    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        q_reg          <= q_next;
        pos_reg        <= pos_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        neg_reg        <= neg_next;
        quot_reg       <= quot_next;
        res_pos_reg    <= res_pos_next;
        res_interp_reg <= res_interp_next;
        if (out_load)
        begin
            out_pos_reg    <= res_pos_reg;
            out_idx_reg    <= INDEX_BITS'(pos_reg);
            out_interp_reg <= res_interp_reg;
        end
    end

    // Advance the sequencer and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign peak_position = out_pos_reg;
    assign peak_index    = out_idx_reg;
    assign interpolated  = out_interp_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> step_reg <= KW'(F - 1))
        else $error("division step counter out of range");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < den_reg)
        else $error("partial remainder not below the denominator");

endmodule

`default_nettype wire

### design/peak_find_parabolic_interp.sv
// Top level of the parabolic peak finder.
//
// Samples stream in one per cycle, with the last of each array marked. The
// front tracks the first largest sample and its neighbors and hands a job to
// a queue of QUEUE_DEPTH entries on each marked sample; only a marked sample
// that meets a full queue is stalled. The back works one job at a time. A
// job with an interior peak is loaded, set up, put through a restoring
// division of FRACTION_BITS (16) quotient bits and finished, and its result
// is moved into the output register. A job with the peak at an edge is
// loaded and its result moved into the output register. Both wait while the
// output register is still full. The front takes in the next array while
// the back still works on earlier jobs. The result is the peak index in
// unsigned fixed point with 16 fraction bits, with the parabolic offset added
// when the peak lies strictly inside the array. Samples past MAX_LENGTH in
// one array are ignored until the marked one.
`default_nettype none

module peak_find_parabolic_interp
    import pfpi_pkg::*;
#(
    parameter int MAX_LENGTH  = MAX_LENGTH_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [POSITION_BITS-1:0]           peak_position,
    output logic [INDEX_BITS-1:0]              peak_index,
    output logic                               interpolated
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    job_t push_job;
    job_t pop_job;

    pfpi_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .last         (last),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    pfpi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (pop_job)
    );

    pfpi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_job         (pop_job),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .peak_position (peak_position),
        .peak_index    (peak_index),
        .interpolated  (interpolated)
    );

endmodule

`default_nettype wire

### test/pfpi_checker.sv
// Checker for the parabolic peak finder: predicts each peak result and compares it.
`timescale 1ns / 100ps

module pfpi_checker
    import pfpi_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    input  logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  logic [POSITION_BITS-1:0]      peak_position,
    input  logic [INDEX_BITS-1:0]         peak_index,
    input  logic                          interpolated,
    output int                            mismatches,
    output int                            pending,
    output int                            results_checked,
    output int                            interp_seen
);

    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic [INDEX_BITS-1:0]    index;
        logic                     interp;
    } peak_result_t;

    // Expected peak results, oldest first
    peak_result_t expected_peaks[$];

    // Tracker state for the array in progress
    logic signed [SAMPLE_BITS-1:0] top_value;
    logic signed [SAMPLE_BITS-1:0] left_value;
    logic signed [SAMPLE_BITS-1:0] right_value;
    logic signed [SAMPLE_BITS-1:0] prior_value;
    logic [INDEX_BITS-1:0]         top_index;
    logic                          right_waiting;
    int unsigned                   seen_count;

    int fail_count;
    int checked_count;
    int interp_count;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                 what, got, want, checked_count);
        fail_count++;
    endtask

    // Start over for the next array
    task automatic clear_tracker();
        top_value     = '0;
        left_value    = '0;
        right_value   = '0;
        prior_value   = '0;
        top_index     = '0;
        right_waiting = 1'b0;
        seen_count    = 0;
    endtask

    // Track one sample; on the marked one, queue the expected peak result
    task automatic track_sample(input logic signed [SAMPLE_BITS-1:0] value,
                                input logic is_last);
        longint unsigned p;
        longint unsigned q;
        longint unsigned den;
        longint unsigned rem;
        longint unsigned quo;
        longint          full_pos;
        logic            interp;
        bit              neg;
        peak_result_t    res;

        // Samples past the length limit are dropped until the marked one
        if (seen_count < MAX_LENGTH) begin
            if (seen_count == 0 || value > top_value) begin
                top_value     = value;
                top_index     = seen_count[INDEX_BITS-1:0];
                left_value    = prior_value;
                right_waiting = 1'b1;
            end
            else if (right_waiting) begin
                right_value   = value;
                right_waiting = 1'b0;
            end
            prior_value = value;
            seen_count++;
        end

        if (is_last) begin
            full_pos = longint'(top_index) << FRACTION_BITS;
            interp   = 1'b0;
            // Interior peak: add floor((p-q) * 2^F / (2(p+q)))
            if (top_index != 0 && !right_waiting) begin
                p   = longint'(top_value) - longint'(left_value);
                q   = longint'(top_value) - longint'(right_value);
                den = 2 * (p + q);
                if (den != 0) begin
                    neg = q > p;
                    rem = neg ? (q - p) : (p - q);
                    quo = 0;
                    for (int k = 0; k < FRACTION_BITS; k++) begin
                        rem = rem << 1;
                        quo = quo << 1;
                        if (rem >= den) begin
                            rem = rem - den;
                            quo = quo | 1;
                        end
                    end
                    if (neg)
                        full_pos = full_pos - longint'(quo) - ((rem != 0) ? 1 : 0);
                    else
                        full_pos = full_pos + longint'(quo);
                    interp = 1'b1;
                end
            end
            res.position = full_pos[POSITION_BITS-1:0];
            res.index    = top_index;
            res.interp   = interp;
            expected_peaks.push_back(res);
            clear_tracker();
        end
    endtask

    // Watch both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        peak_result_t want;
        if (!rst_n) begin
            clear_tracker();
            expected_peaks.delete();
            fail_count      = 0;
            checked_count   = 0;
            interp_count    = 0;
            mismatches      <= 0;
            pending         <= 0;
            results_checked <= 0;
            interp_seen     <= 0;
        end
        else begin
            // Compare a result transfer with the oldest expectation
            if (result_valid && result_ready) begin
                if (expected_peaks.size() == 0) begin
                    report_mismatch("result with nothing expected, position",
                                    peak_position, 0);
                end
                else begin
                    want = expected_peaks.pop_front();
                    if (peak_position !== want.position)
                        report_mismatch("peak_position", peak_position, want.position);
                    if (peak_index !== want.index)
                        report_mismatch("peak_index", peak_index, want.index);
                    if (interpolated !== want.interp)
                        report_mismatch("interpolated", interpolated, want.interp);
                    if (want.interp)
                        interp_count++;
                end
                checked_count++;
            end

            // Predict from a sample transfer
            if (sample_valid && sample_ready)
                track_sample(sample, last);

            mismatches      <= fail_count;
            pending         <= expected_peaks.size();
            results_checked <= checked_count;
            interp_seen     <= interp_count;
        end
    end

endmodule

### test/tb_peak_find_parabolic_interp.sv
// Testbench top for the parabolic peak finder: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_peak_find_parabolic_interp;
    import pfpi_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 300;
    localparam int DRAIN_WAIT  = 64;

    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_TIGHT,
        SPREAD_HIGH,
        SPREAD_LOW
    } spread_t;

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          result_valid;
    logic                          result_ready;
    logic [POSITION_BITS-1:0]      peak_position;
    logic [INDEX_BITS-1:0]         peak_index;
    logic                          interpolated;

    int mismatches;
    int pending;
    int results_checked;
    int interp_seen;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  cycle_count;
    int  samples_sent;
    int  arrays_sent;

    peak_find_parabolic_interp u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .last          (last),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .peak_position (peak_position),
        .peak_index    (peak_index),
        .interpolated  (interpolated)
    );

    pfpi_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .last            (last),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .peak_position   (peak_position),
        .peak_index      (peak_index),
        .interpolated    (interpolated),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .interp_seen     (interp_seen)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycle_count, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        result_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else begin
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one sample after a random gap and hold it until the transfer
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                               input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        last         <= is_last;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        samples_sent++;
        if (is_last)
            arrays_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_value(input spread_t spread);
        case (spread)
            SPREAD_TIGHT: return $signed($urandom_range(6)) - 3;
            SPREAD_HIGH:  return S_MAX - $signed($urandom_range(7));
            SPREAD_LOW:   return S_MIN + $signed($urandom_range(7));
            default:      return $urandom;
        endcase
    endfunction

    // One array of random content, of the given length and spread
    task automatic send_array(input int len, input spread_t spread);
        for (int i = 0; i < len; i++)
            send_sample(pick_value(spread), i == len - 1);
    endtask

    task automatic send_random_arrays(input int items);
        int start;
        int pick;
        int len;
        start = samples_sent;
        while (samples_sent - start < items) begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(8, 1);
            else if (pick < 95)
                len = $urandom_range(40, 9);
            else
                len = $urandom_range(200, 41);
            send_array(len, spread_t'($urandom_range(3)));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        last           = 1'b0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        samples_sent   = 0;
        arrays_sent    = 0;

        // Hold reset, then release it on a falling edge
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single-sample arrays at both extremes
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b1);
        // Peak on the first sample
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b1);
        // Peak on the final sample
        send_sample(S_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample(S_MAX, 1'b1);
        // Interior peak, symmetric neighbors: zero offset
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b1);
        // Interior peak leaning right, offset close to +1/2
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX - 1, 1'b1);
        // Interior peak leaning left, offset close to -1/2
        send_sample(S_MAX - 1, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b1);
        // Flat array: first occurrence wins at the edge
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd5, 1'b1);
        // Repeated peak later on: earlier one kept
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd2, 1'b1);

        // Random arrays under each idle mix
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random_arrays(PHASE_ITEMS);
        send_idle_pct = 81; recv_stall_pct = 0;  send_random_arrays(PHASE_ITEMS);
        send_idle_pct = 0;  recv_stall_pct = 81; send_random_arrays(PHASE_ITEMS);
        send_idle_pct = 31; recv_stall_pct = 31; send_random_arrays(PHASE_ITEMS);

        // Hold the output off while short arrays keep coming, to back up the input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        for (int n = 0; n < 40; n++)
            send_array(2, spread_t'($urandom_range(3)));

        // Drop valid and drain
        sample_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d samples in %0d arrays; checked %0d results, %0d interpolated.",
                 samples_sent, arrays_sent, results_checked, interp_seen);
        $display("Covered edge and interior peaks, four idle mixes and a long output hold-off.");
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
